[sv/mlfs_pkg.sv]
// Package with the item types, codes and sizes of the multilevel feedback scheduler.
package mlfs_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int NUM_Q     = 5;
    localparam int Q_W       = $clog2(NUM_Q);
    localparam int NUM_LVL   = 4;
    localparam int LVL_W     = 2;

    localparam logic [Q_W-1:0] BLOCKED_Q = Q_W'(4);

    localparam logic [19:0] QUANTUM_RESET = 20'd10000;

    localparam logic [1:0] CMD_ADMIT    = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_REPORT   = 2'd2;

    localparam logic [1:0] OUT_RUNNING    = 2'd0;
    localparam logic [1:0] OUT_TERMINATED = 2'd1;
    localparam logic [1:0] OUT_BLOCKED    = 2'd2;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE       = 2'd2;

    localparam logic [LVL_W-1:0] LVL_REAL_TIME = LVL_W'(0);
    localparam logic [LVL_W-1:0] LVL_USER      = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_LAST      = LVL_W'(3);

    typedef struct packed {
        logic [1:0]  command;
        logic [21:0] task_id;
        logic        real_time;
        logic [3:0]  report_slot;
        logic [1:0]  outcome;
        logic [47:0] wake_time;
        logic [22:0] unused_slice;
        logic [47:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [21:0] dispatched_id;
        logic [2:0]  from_queue;
        logic [22:0] time_slice;
    } t_out_item;

endpackage

[sv/multilevel_feedback_scheduler.sv]
// Multilevel feedback queue scheduler with slot table, blocked queue and four level queues.
//
// Usage: each input item carries one command (admit, dispatch or report) and
// produces exactly one result item. The input channel (i_in_valid, o_in_stall)
// feeds an input register; all table and queue work for that command is done
// combinationally between the input register and the result register, which
// drives the output channel (o_out_valid, i_out_stall). Results are registered,
// and one item is accepted per cycle as long as results are taken. When the
// receiver stalls, the result is held and the input register still takes one
// more item if it is empty; then o_in_stall rises. The base quantum register
// is written by i_cfg_we and i_cfg_wdata; the user must write it only while no
// item is in flight, which the block itself does not enforce. Synchronous
// reset empties all queues, frees all slots, drops any item in flight and sets
// the base quantum to 10000; no clearing pass is needed, so items are taken
// as soon as reset is released.
module multilevel_feedback_scheduler
    import mlfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata
);

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [19:0]       r_quantum;

    logic [SLOTS-1:0]  r_busy;
    logic [21:0]       r_task     [SLOTS];
    logic [LVL_W-1:0]  r_level    [SLOTS];
    logic [47:0]       r_wake     [SLOTS];
    logic [22:0]       r_leftover [SLOTS];

    logic [SLOT_W-1:0] r_fifo  [NUM_Q][SLOTS];
    logic [SLOT_W-1:0] r_head  [NUM_Q];
    logic [CNT_W-1:0]  r_count [NUM_Q];

    logic              adv;
    logic              in_take;
    t_out_item         n_out;

    logic [SLOT_W-1:0] front [NUM_Q];
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic [SLOT_W-1:0] blk_slot;
    logic              blk_due;
    logic              lvl_found;
    logic [LVL_W-1:0]  lvl_sel;
    logic [SLOT_W-1:0] lvl_slot;
    logic [SLOT_W-1:0] rep_idx;
    logic              rep_ok;
    logic [LVL_W-1:0]  rep_lvl;
    logic [LVL_W-1:0]  next_lvl;

    logic              push_en;
    logic [Q_W-1:0]    push_q;
    logic [SLOT_W-1:0] push_slot;
    logic              pop_en;
    logic [Q_W-1:0]    pop_q;
    logic              set_busy;
    logic              clr_busy;
    logic              wr_level;
    logic [SLOT_W-1:0] lvl_idx;
    logic [LVL_W-1:0]  lvl_val;
    logic              wr_wake;

    function automatic logic [SLOT_W-1:0] wrap_idx(input logic [SLOT_W:0] v);
        logic [SLOT_W:0] w;
        w = (v >= (SLOT_W+1)'(SLOTS)) ? v - (SLOT_W+1)'(SLOTS) : v;
        return w[SLOT_W-1:0];
    endfunction

    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        for (int q = 0; q < NUM_Q; q++) begin
            front[q] = r_fifo[q][r_head[q]];
        end
    end

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
        lvl_found = 1'b0;
        lvl_sel   = '0;
        for (int l = NUM_LVL - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                lvl_found = 1'b1;
                lvl_sel   = LVL_W'(l);
            end
        end
    end

    assign blk_slot = front[BLOCKED_Q];
    assign blk_due  = (r_count[BLOCKED_Q] != '0) && (r_in.now_time >= r_wake[blk_slot]);
    assign lvl_slot = front[Q_W'(lvl_sel)];
    assign rep_idx  = SLOT_W'(r_in.report_slot);
    assign rep_ok   = (32'(r_in.report_slot) < SLOTS) && r_busy[rep_idx];
    assign rep_lvl  = r_level[rep_idx];

    always_comb begin
        case (rep_lvl)
            LVL_REAL_TIME: next_lvl = LVL_REAL_TIME;
            LVL_LAST:      next_lvl = LVL_USER;
            default:       next_lvl = rep_lvl + LVL_W'(1);
        endcase
    end

    always_comb begin
        n_out     = '0;
        push_en   = 1'b0;
        push_q    = '0;
        push_slot = '0;
        pop_en    = 1'b0;
        pop_q     = '0;
        set_busy  = 1'b0;
        clr_busy  = 1'b0;
        wr_level  = 1'b0;
        lvl_idx   = free_slot;
        lvl_val   = r_in.real_time ? LVL_REAL_TIME : LVL_USER;
        wr_wake   = 1'b0;
        case (r_in.command)
            CMD_ADMIT: begin
                if (!free_found) begin
                    n_out.status = ST_TABLE_FULL;
                end else begin
                    set_busy   = 1'b1;
                    wr_level   = 1'b1;
                    push_en    = 1'b1;
                    push_q     = Q_W'(lvl_val);
                    push_slot  = free_slot;
                    n_out.slot = 4'(free_slot);
                end
            end
            CMD_DISPATCH: begin
                if (blk_due) begin
                    pop_en              = 1'b1;
                    pop_q               = BLOCKED_Q;
                    n_out.slot          = 4'(blk_slot);
                    n_out.dispatched_id = r_task[blk_slot];
                    n_out.from_queue    = 3'(BLOCKED_Q);
                    n_out.time_slice    = r_leftover[blk_slot];
                end else if (lvl_found) begin
                    pop_en              = 1'b1;
                    pop_q               = Q_W'(lvl_sel);
                    n_out.slot          = 4'(lvl_slot);
                    n_out.dispatched_id = r_task[lvl_slot];
                    n_out.from_queue    = 3'(lvl_sel);
                    n_out.time_slice    = 23'(r_quantum) << lvl_sel;
                end else begin
                    n_out.status = ST_IDLE;
                end
            end
            CMD_REPORT: begin
                if (rep_ok) begin
                    case (r_in.outcome)
                        OUT_TERMINATED: begin
                            clr_busy = 1'b1;
                        end
                        OUT_BLOCKED: begin
                            wr_wake   = 1'b1;
                            push_en   = 1'b1;
                            push_q    = BLOCKED_Q;
                            push_slot = rep_idx;
                        end
                        OUT_RUNNING: begin
                            wr_level  = 1'b1;
                            lvl_idx   = rep_idx;
                            lvl_val   = next_lvl;
                            push_en   = 1'b1;
                            push_q    = Q_W'(next_lvl);
                            push_slot = rep_idx;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_quantum   <= QUANTUM_RESET;
            r_busy      <= '0;
            for (int q = 0; q < NUM_Q; q++) begin
                r_head[q]  <= '0;
                r_count[q] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                if (set_busy) begin
                    r_busy[free_slot] <= 1'b1;
                end
                if (clr_busy) begin
                    r_busy[rep_idx] <= 1'b0;
                end
                if (push_en && (r_count[push_q] < CNT_W'(SLOTS))) begin
                    r_count[push_q] <= r_count[push_q] + CNT_W'(1);
                end
                if (pop_en) begin
                    r_head[pop_q]  <= wrap_idx({1'b0, r_head[pop_q]} + (SLOT_W+1)'(1));
                    r_count[pop_q] <= r_count[pop_q] - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (adv) begin
            r_out <= n_out;
            if (set_busy) begin
                r_task[free_slot] <= r_in.task_id;
            end
            if (wr_level) begin
                r_level[lvl_idx] <= lvl_val;
            end
            if (wr_wake) begin
                r_wake[rep_idx]     <= r_in.wake_time;
                r_leftover[rep_idx] <= r_in.unused_slice;
            end
            if (push_en && (r_count[push_q] < CNT_W'(SLOTS))) begin
                r_fifo[push_q][wrap_idx({1'b0, r_head[push_q]}
                    + (SLOT_W+1)'(r_count[push_q]))] <= push_slot;
            end
        end
    end

endmodule

[verif/multilevel_feedback_scheduler_tb.sv]
// Self-checking testbench for the multilevel feedback scheduler: directed table, then random traffic.
`timescale 1ns / 100ps

module multilevel_feedback_scheduler_tb;
    import mlfs_pkg::*;

    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam logic [1:0] OUT_UNKNOWN = 2'd3;
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 345;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_we;
    logic [19:0] i_cfg_wdata;

    bit                slot_busy  [SLOTS];
    logic [21:0]       slot_task  [SLOTS];
    logic [LVL_W-1:0]  slot_level [SLOTS];
    logic [47:0]       slot_wake  [SLOTS];
    logic [22:0]       slot_left  [SLOTS];
    logic [SLOT_W-1:0] q_store    [NUM_Q][SLOTS];
    int                q_head     [NUM_Q];
    int                q_count    [NUM_Q];
    logic [19:0]       quantum;
    logic [47:0]       sim_clock;

    t_out_item owed_results[$];
    bit        pin_flag[$];
    t_out_item pin_value[$];
    t_in_item  plan_in[$];
    bit        plan_pinned[$];
    t_out_item plan_want[$];

    int        idle_pct;
    int        errors;
    int        stuck_cycles;
    bit        in_taken;
    bit        out_taken;
    bit        pinned_now;
    t_out_item pinned_val;
    t_out_item owed_now;

    multilevel_feedback_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void queue_slot(input int q, input int s);
        if (q_count[q] >= SLOTS) return;
        q_store[q][(q_head[q] + q_count[q]) % SLOTS] = SLOT_W'(s);
        q_count[q]++;
    endfunction

    function automatic int take_slot(input int q);
        int s;
        s = q_store[q][q_head[q]];
        q_head[q] = (q_head[q] + 1) % SLOTS;
        q_count[q]--;
        return s;
    endfunction

    function automatic t_out_item sched_apply(input t_in_item it);
        t_out_item r;
        int        s;
        int        lv;
        r = '0;
        case (it.command)
            CMD_ADMIT: begin
                s = 0;
                while (s < SLOTS && slot_busy[s]) s++;
                if (s == SLOTS) begin
                    r.status = ST_TABLE_FULL;
                end else begin
                    slot_busy[s]  = 1'b1;
                    slot_task[s]  = it.task_id;
                    slot_level[s] = it.real_time ? LVL_REAL_TIME : LVL_USER;
                    queue_slot(slot_level[s], s);
                    r.slot = SLOT_W'(s);
                end
            end
            CMD_DISPATCH: begin
                if (q_count[BLOCKED_Q] > 0 &&
                    it.now_time >= slot_wake[q_store[BLOCKED_Q][q_head[BLOCKED_Q]]]) begin
                    s = take_slot(BLOCKED_Q);
                    r.slot          = SLOT_W'(s);
                    r.dispatched_id = slot_task[s];
                    r.from_queue    = BLOCKED_Q;
                    r.time_slice    = slot_left[s];
                end else begin
                    r.status = ST_IDLE;
                    for (lv = 0; lv < NUM_LVL && r.status == ST_IDLE; lv++) begin
                        if (q_count[lv] > 0) begin
                            s = take_slot(lv);
                            r.status        = ST_DONE;
                            r.slot          = SLOT_W'(s);
                            r.dispatched_id = slot_task[s];
                            r.from_queue    = 3'(lv);
                            r.time_slice    = 23'(quantum) << lv;
                        end
                    end
                end
            end
            CMD_REPORT: begin
                s = it.report_slot;
                if (slot_busy[s]) begin
                    case (it.outcome)
                        OUT_TERMINATED: slot_busy[s] = 1'b0;
                        OUT_BLOCKED: begin
                            slot_wake[s] = it.wake_time;
                            slot_left[s] = it.unused_slice;
                            queue_slot(BLOCKED_Q, s);
                        end
                        OUT_RUNNING: begin
                            if (slot_level[s] == LVL_LAST) begin
                                slot_level[s] = LVL_USER;
                            end else if (slot_level[s] != LVL_REAL_TIME) begin
                                slot_level[s] = slot_level[s] + 1'b1;
                            end
                            queue_slot(slot_level[s], s);
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_item mk(input logic [1:0] cmd, input logic [21:0] id,
                                    input logic rt, input logic [3:0] rs,
                                    input logic [1:0] oc, input logic [47:0] wk,
                                    input logic [22:0] us, input logic [47:0] nw);
        t_in_item it;
        it.command      = cmd;
        it.task_id      = id;
        it.real_time    = rt;
        it.report_slot  = rs;
        it.outcome      = oc;
        it.wake_time    = wk;
        it.unused_slice = us;
        it.now_time     = nw;
        return it;
    endfunction

    function automatic t_out_item res(input logic [1:0] st, input logic [3:0] sl,
                                      input logic [21:0] id, input logic [2:0] fq,
                                      input logic [22:0] ts);
        t_out_item r;
        r.status        = st;
        r.slot          = sl;
        r.dispatched_id = id;
        r.from_queue    = fq;
        r.time_slice    = ts;
        return r;
    endfunction

    function automatic void add_row(input t_in_item it, input bit pin, input t_out_item want);
        plan_in.push_back(it);
        plan_pinned.push_back(pin);
        plan_want.push_back(want);
    endfunction

    function automatic t_in_item rand_item(input int admit_pct);
        t_in_item it;
        int       pick;
        int       busy_list[$];
        it.command      = CMD_NONE;
        it.task_id      = 22'($urandom);
        it.real_time    = 1'($urandom);
        it.report_slot  = 4'($urandom);
        it.outcome      = 2'($urandom);
        it.wake_time    = 48'({$urandom, $urandom});
        it.unused_slice = 23'($urandom);
        it.now_time     = 48'({$urandom, $urandom});
        sim_clock = sim_clock + 48'($urandom_range(200));
        pick = $urandom_range(99);
        if (pick < 2) begin
            it.command = CMD_NONE;
        end else if (pick < 2 + admit_pct) begin
            it.command = CMD_ADMIT;
        end else if (pick < 32 + admit_pct) begin
            it.command = CMD_DISPATCH;
            if ($urandom_range(9) != 0) it.now_time = sim_clock;
        end else begin
            it.command = CMD_REPORT;
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_busy[s]) busy_list.push_back(s);
            end
            if (busy_list.size() != 0 && $urandom_range(99) < 85) begin
                it.report_slot = 4'(busy_list[$urandom_range(busy_list.size() - 1)]);
            end
            pick = $urandom_range(99);
            it.outcome = pick < 45 ? OUT_RUNNING : pick < 65 ? OUT_TERMINATED :
                         pick < 95 ? OUT_BLOCKED : OUT_UNKNOWN;
            if ($urandom_range(9) != 0) it.wake_time = sim_clock + 48'($urandom_range(3000));
        end
        return it;
    endfunction

    task automatic offer_item(input t_in_item it, input bit pin, input t_out_item want);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        pin_flag.push_back(pin);
        pin_value.push_back(want);
        @(negedge i_clk);
        while (!in_taken) @(negedge i_clk);
    endtask

    task automatic settle(input int tail);
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        in_taken  = i_rst_n && i_in_valid && !o_in_stall;
        out_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n) begin
            if (i_cfg_we) quantum = i_cfg_wdata;
            if (in_taken) begin
                pinned_now = pin_flag.pop_front();
                pinned_val = pin_value.pop_front();
                owed_now   = sched_apply(i_in_item);
                owed_results.push_back(pinned_now ? pinned_val : owed_now);
            end
            if (out_taken) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_item);
                    errors++;
                end else begin
                    owed_now = owed_results.pop_front();
                    if (o_out_item.status !== owed_now.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, owed_now.status, o_out_item.status);
                        errors++;
                    end
                    if (o_out_item.slot !== owed_now.slot) begin
                        $display("%0t: slot expected %0d got %0d",
                                 $time, owed_now.slot, o_out_item.slot);
                        errors++;
                    end
                    if (o_out_item.dispatched_id !== owed_now.dispatched_id) begin
                        $display("%0t: dispatched_id expected %h got %h",
                                 $time, owed_now.dispatched_id, o_out_item.dispatched_id);
                        errors++;
                    end
                    if (o_out_item.from_queue !== owed_now.from_queue) begin
                        $display("%0t: from_queue expected %0d got %0d",
                                 $time, owed_now.from_queue, o_out_item.from_queue);
                        errors++;
                    end
                    if (o_out_item.time_slice !== owed_now.time_slice) begin
                        $display("%0t: time_slice expected %0d got %0d",
                                 $time, owed_now.time_slice, o_out_item.time_slice);
                        errors++;
                    end
                end
            end
            if (in_taken || out_taken) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("multilevel_feedback_scheduler_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin : run
        logic [19:0] phase_quanta [4];
        int          phase_admit  [4];
        int          n;
        int          ph;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        idle_pct     = 22;
        errors       = 0;
        stuck_cycles = 0;
        sim_clock    = '0;
        quantum      = QUANTUM_RESET;
        for (n = 0; n < SLOTS; n++) begin
            slot_busy[n]  = 1'b0;
            slot_task[n]  = '0;
            slot_level[n] = '0;
            slot_wake[n]  = '0;
            slot_left[n]  = '0;
            for (ph = 0; ph < NUM_Q; ph++) q_store[ph][n] = '0;
        end
        for (ph = 0; ph < NUM_Q; ph++) begin
            q_head[ph]  = 0;
            q_count[ph] = 0;
        end
        phase_quanta = '{20'd1, 20'hFFFFF, 20'($urandom_range(1048574, 2)), QUANTUM_RESET};
        phase_admit  = '{45, 10, 25, 10};

        add_row(mk(CMD_DISPATCH, 0, 0, 0, OUT_RUNNING, 0, 0, 0), 1, res(ST_IDLE, 0, 0, 0, 0));
        add_row(mk(CMD_REPORT, 0, 0, 0, OUT_RUNNING, 0, 0, 0), 1, res(ST_DONE, 0, 0, 0, 0));
        add_row(mk(CMD_NONE, '1, 1, '1, '1, '1, '1, '1), 1, res(ST_DONE, 0, 0, 0, 0));
        add_row(mk(CMD_ADMIT, '1, 1, 0, 0, 0, 0, 0), 1, res(ST_DONE, 0, 0, 0, 0));
        add_row(mk(CMD_ADMIT, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_DONE, 1, 0, 0, 0));
        add_row(mk(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0), 1,
                res(ST_DONE, 0, 22'h3FFFFF, 0, 23'd10000));
        add_row(mk(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_DONE, 1, 0, 1, 23'd20000));
        add_row(mk(CMD_REPORT, 0, 0, 1, OUT_RUNNING, 0, 0, 0), 1, res(ST_DONE, 0, 0, 0, 0));
        add_row(mk(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_DONE, 1, 0, 2, 23'd40000));
        add_row(mk(CMD_REPORT, 0, 0, 1, OUT_RUNNING, 0, 0, 0), 1, res(ST_DONE, 0, 0, 0, 0));
        add_row(mk(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_DONE, 1, 0, 3, 23'd80000));
        add_row(mk(CMD_REPORT, 0, 0, 1, OUT_RUNNING, 0, 0, 0), 0, '0);
        add_row(mk(CMD_REPORT, 0, 0, 0, OUT_RUNNING, 0, 0, 0), 0, '0);
        add_row(mk(CMD_REPORT, 0, 0, 0, OUT_BLOCKED, '1, '1, 0), 0, '0);
        add_row(mk(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, '1), 1,
                res(ST_DONE, 0, 22'h3FFFFF, BLOCKED_Q, '1));
        add_row(mk(CMD_REPORT, 0, 0, 0, OUT_UNKNOWN, 0, 0, 0), 0, '0);
        add_row(mk(CMD_REPORT, 0, 0, 15, OUT_TERMINATED, 0, 0, 0), 0, '0);
        add_row(mk(CMD_REPORT, 0, 0, 0, OUT_TERMINATED, 0, 0, 0), 0, '0);
        add_row(mk(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(CMD_ADMIT, 22'h2AAAAA, 1, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(CMD_REPORT, 0, 0, 0, OUT_TERMINATED, 0, 0, 0), 0, '0);
        add_row(mk(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0), 0, '0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < plan_in.size(); n++) begin
            offer_item(plan_in[n], plan_pinned[n], plan_want[n]);
        end

        for (ph = 0; ph < 4; ph++) begin
            settle(4);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= phase_quanta[ph];
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            idle_pct = (ph == 2) ? 0 : 22;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == PHASE_ITEMS / 2) settle(4);
                offer_item(rand_item(phase_admit[ph]), 1'b0, '0);
            end
        end

        settle(10);
        if (errors == 0) begin
            $display("multilevel_feedback_scheduler_tb: done, clean");
        end else begin
            $display("multilevel_feedback_scheduler_tb: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/mlfs_pkg.sv
sv/multilevel_feedback_scheduler.sv
verif/multilevel_feedback_scheduler_tb.sv
